// ===== hdl/pccc_pkg.sv =====
// Shared constants, types and helper functions for the planar chain closure check.
// Used by pccc_sincos, pccc_mul and planar_chain_closure_check_top; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pccc_pkg;

	localparam int MAX_LINKS    = 64;
	localparam int CORDIC_STEPS = 16;
	localparam int CORDIC_ITERS = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;

	localparam int ANG_W = 27;
	localparam int POS_W = 32;
	localparam int CRD_W = 34;
	localparam int RED_W = 21;
	localparam int MUL_W = 35;

	localparam logic [26:0]        TWO_PI_RAW = 27'd411775;
	localparam logic signed [27:0] TWO_PI_Q16 = 28'sd411775;
	localparam logic signed [20:0] TWO_PI_R   = 21'sd411775;
	localparam logic signed [20:0] PI_Q16     = 21'sd205887;
	localparam logic signed [20:0] HALF_PI    = 21'sd102944;
	localparam logic signed [33:0] CORDIC_K   = 34'sd652032874;

	localparam logic signed [26:0] ANG_MAX = 27'sh3FFFFFF;
	localparam logic signed [26:0] ANG_MIN = -27'sh4000000;

	// Configuration register indexes.
	localparam logic REG_LINK_COUNT = 1'b0;
	localparam logic REG_TOLERANCE  = 1'b1;

	typedef struct packed {
		logic busy;
		logic done;
	} sc_stat_t;

	function automatic logic [29:0] atan_q30(input logic [4:0] idx);
		logic [29:0] v;
		case (idx)
			5'd0:  v = 30'd843314857;
			5'd1:  v = 30'd497837830;
			5'd2:  v = 30'd263043837;
			5'd3:  v = 30'd133525159;
			5'd4:  v = 30'd67021687;
			5'd5:  v = 30'd33543515;
			5'd6:  v = 30'd16775851;
			5'd7:  v = 30'd8388438;
			5'd8:  v = 30'd4194283;
			5'd9:  v = 30'd2097149;
			5'd10: v = 30'd1048576;
			5'd11: v = 30'd524288;
			5'd12: v = 30'd262144;
			5'd13: v = 30'd131072;
			5'd14: v = 30'd65536;
			5'd15: v = 30'd32768;
			5'd16: v = 30'd16384;
			5'd17: v = 30'd8192;
			5'd18: v = 30'd4096;
			5'd19: v = 30'd2048;
			5'd20: v = 30'd1024;
			5'd21: v = 30'd512;
			5'd22: v = 30'd256;
			5'd23: v = 30'd128;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

	function automatic logic signed [31:0] sat_pos(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v > 34'sh07FFFFFFF)
			r = 32'sh7FFFFFFF;
		else if (v < -34'sh080000000)
			r = -32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

	function automatic logic signed [26:0] sat_ang(input logic signed [27:0] v);
		logic signed [26:0] r;
		if (v > 28'(ANG_MAX))
			r = ANG_MAX;
		else if (v < 28'(ANG_MIN))
			r = ANG_MIN;
		else
			r = v[26:0];
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/pccc_sincos.sv =====
// Iterative sine and cosine: angle reduction by shifted subtraction, then CORDIC rotation.
// Depends on pccc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pccc_sincos import pccc_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic signed [ANG_W-1:0] angle,
	output sc_stat_t                     stat,
	output logic signed [CRD_W-1:0]      cos_val,
	output logic signed [CRD_W-1:0]      sin_val
);

	localparam logic [1:0] P_IDLE = 2'd0;
	localparam logic [1:0] P_MOD  = 2'd1;
	localparam logic [1:0] P_ROT  = 2'd2;

	logic [1:0]              phase_q;
	logic [ANG_W-1:0]        mag_q;
	logic                    neg_q;
	logic [2:0]              k_q;
	logic [4:0]              i_q;
	logic                    flip_q;
	logic                    done_q;
	logic signed [CRD_W-1:0] x_q, y_q, z_q;
	logic signed [CRD_W-1:0] cos_q, sin_q;

	logic [ANG_W-1:0]        cand;
	logic [ANG_W-1:0]        mag_next;
	logic signed [27:0]      rem_s;
	logic signed [RED_W-1:0] r1, r2;
	logic                    flip_n;
	logic signed [CRD_W-1:0] dx, dy, at, xn, yn, zn;

	// One shifted multiple of two pi per cycle gives the truncating remainder.
	always_comb begin
		cand     = TWO_PI_RAW << k_q;
		mag_next = (mag_q >= cand) ? mag_q - cand : mag_q;
		rem_s    = neg_q ? -$signed({1'b0, mag_next}) : $signed({1'b0, mag_next});
		r1       = rem_s[RED_W-1:0];
		if (r1 > PI_Q16)
			r1 = r1 - TWO_PI_R;
		else if (r1 < -PI_Q16)
			r1 = r1 + TWO_PI_R;
		flip_n = 1'b0;
		r2     = r1;
		if (r1 > HALF_PI) begin
			r2     = r1 - PI_Q16;
			flip_n = 1'b1;
		end else if (r1 < -HALF_PI) begin
			r2     = r1 + PI_Q16;
			flip_n = 1'b1;
		end
	end

	always_comb begin
		dx = y_q >>> i_q;
		dy = x_q >>> i_q;
		at = {4'b0, atan_q30(i_q)};
		if (!z_q[CRD_W-1]) begin
			xn = x_q - dx;
			yn = y_q + dy;
			zn = z_q - at;
		end else begin
			xn = x_q + dx;
			yn = y_q - dy;
			zn = z_q + at;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (phase_q)
				P_IDLE: begin
					if (start)
						phase_q <= P_MOD;
				end
				P_MOD: begin
					if (k_q == 3'd0)
						phase_q <= P_ROT;
				end
				P_ROT: begin
					if (i_q == 5'(CORDIC_ITERS - 1)) begin
						phase_q <= P_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: phase_q <= P_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (phase_q)
			P_IDLE: begin
				neg_q <= angle[ANG_W-1];
				mag_q <= angle[ANG_W-1] ? ANG_W'(-angle) : ANG_W'(angle);
				k_q   <= 3'd7;
			end
			P_MOD: begin
				mag_q <= mag_next;
				k_q   <= k_q - 3'd1;
				x_q    <= CORDIC_K;
				y_q    <= '0;
				z_q    <= CRD_W'(r2) <<< 14;
				flip_q <= flip_n;
				i_q    <= 5'd0;
			end
			P_ROT: begin
				x_q <= xn;
				y_q <= yn;
				z_q <= zn;
				i_q <= i_q + 5'd1;
				cos_q <= flip_q ? -xn : xn;
				sin_q <= flip_q ? -yn : yn;
			end
			default: ;
		endcase
	end

	assign stat.busy = (phase_q != P_IDLE);
	assign stat.done = done_q;
	assign cos_val   = cos_q;
	assign sin_val   = sin_q;

	a_done_after_rot: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(phase_q == P_ROT))
		else $error("done without a rotation");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == P_MOD && k_q == 3'd0) |=> (phase_q == P_ROT && i_q == 5'd0))
		else $error("rotation did not start clean");
	a_no_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> phase_q == P_IDLE)
		else $error("done while busy");

endmodule

`default_nettype wire

// ===== hdl/pccc_mul.sv =====
// Shared signed multiplier with a registered product, used for link vectors and squares.
// Depends on pccc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pccc_mul import pccc_pkg::*; (
	input  wire logic                      clk,
	input  wire logic signed [MUL_W-1:0]   op_a,
	input  wire logic signed [MUL_W-1:0]   op_b,
	output logic signed [2*MUL_W-1:0]      prod
);

	logic signed [2*MUL_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
	end

	assign prod = prod_q;

endmodule

`default_nettype wire

// ===== hdl/planar_chain_closure_check_top.sv =====
// Top level of the planar chain closure check: sequencer, chain state and result register.
// Depends on pccc_pkg, pccc_sincos and pccc_mul.
//
// Usage: joints of a planar chain arrive one item at a time on the input channel
// (in_valid / in_stall), in chain order, each with its angle and link length.
// The item with final_joint set closes the chain. Every item yields exactly one
// result item on the output channel (out_valid / out_stall) holding the end point
// of that link. The result for the final joint also carries the angle residual,
// the closure flag and the count status, after which the chain state clears.
// One item at a time: the next item is accepted only after the result of the
// last one has left the sequencer for the output register. The time is set by
// the shared CORDIC unit (8 reduction steps plus 16 rotation steps) and by the
// shared multiplier, used twice per joint and four more times on the final one.
// in_stall is high while an item is in work. A finished result sits in the output
// register; a stalled receiver holds it, and the next result waits in the
// sequencer until the register is free. Reset clears the chain state, the
// output valid and the registers to link_count 4 and closure_tolerance 66.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect immediately.
`timescale 1ns / 1ps
`default_nettype none

module planar_chain_closure_check_top import pccc_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic signed [19:0]      joint_angle,
	input  wire logic [15:0]             link_len,
	input  wire logic                    final_joint,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic signed [31:0]           pos_x,
	output logic signed [31:0]           pos_y,
	output logic signed [26:0]           angle_residual,
	output logic                         closes,
	output logic                         status,
	output logic                         end_of_chain,
	input  wire logic                    cfg_we,
	input  wire logic                    cfg_index,
	input  wire logic [31:0]             cfg_data
);

	localparam logic [3:0] T_IDLE = 4'd0;
	localparam logic [3:0] T_ANG  = 4'd1;
	localparam logic [3:0] T_WAIT = 4'd2;
	localparam logic [3:0] T_MX   = 4'd3;
	localparam logic [3:0] T_MY   = 4'd4;
	localparam logic [3:0] T_PY   = 4'd5;
	localparam logic [3:0] T_SX   = 4'd6;
	localparam logic [3:0] T_SY   = 4'd7;
	localparam logic [3:0] T_SR   = 4'd8;
	localparam logic [3:0] T_ST   = 4'd9;
	localparam logic [3:0] T_CMP  = 4'd10;
	localparam logic [3:0] T_OUT  = 4'd11;

	logic [3:0]              state_q;
	logic [6:0]              link_count_q;
	logic [31:0]             tol_q;
	logic signed [ANG_W-1:0] angle_q;
	logic signed [POS_W-1:0] end_x_q, end_y_q;
	logic [6:0]              jidx_q;
	logic signed [19:0]      ang_in_q;
	logic [15:0]             len_q;
	logic                    last_q;
	logic signed [ANG_W-1:0] res_q;
	logic [64:0]             sum_q;
	logic                    closes_q;

	logic                    out_valid_q;
	logic signed [31:0]      pos_x_q, pos_y_q;
	logic signed [26:0]      res_out_q;
	logic                    closes_out_q, status_out_q, eoc_q;

	sc_stat_t                sc_stat;
	logic signed [CRD_W-1:0] cos_v, sin_v;
	logic signed [MUL_W-1:0] mul_a, mul_b;
	logic signed [2*MUL_W-1:0] prod;

	logic signed [ANG_W-1:0] angle_n;
	logic [49:0]             rnd;
	logic signed [27:0]      delta;
	logic signed [33:0]      pos_sum_x, pos_sum_y;
	logic                    out_free, load_out, status_n;

	// The cumulative angle including the joint in work; the sine unit samples it
	// in the same cycle that it starts.
	assign angle_n = sat_ang(28'(angle_q) + 28'(ang_in_q));

	pccc_sincos u_sincos (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (state_q == T_ANG),
		.angle   (angle_n),
		.stat    (sc_stat),
		.cos_val (cos_v),
		.sin_val (sin_v)
	);

	pccc_mul u_mul (
		.clk  (clk),
		.op_a (mul_a),
		.op_b (mul_b),
		.prod (prod)
	);

	// Operand selection for the shared multiplier; its product is registered and shows in the next cycle.
	always_comb begin
		case (state_q)
			T_MX: begin
				mul_a = $signed({19'b0, len_q});
				mul_b = MUL_W'(cos_v);
			end
			T_MY: begin
				mul_a = $signed({19'b0, len_q});
				mul_b = MUL_W'(sin_v);
			end
			T_SX: begin
				mul_a = MUL_W'(end_x_q);
				mul_b = MUL_W'(end_x_q);
			end
			T_SY: begin
				mul_a = MUL_W'(end_y_q);
				mul_b = MUL_W'(end_y_q);
			end
			T_SR: begin
				mul_a = MUL_W'(res_q);
				mul_b = MUL_W'(res_q);
			end
			default: begin
				mul_a = $signed({3'b0, tol_q});
				mul_b = $signed({3'b0, tol_q});
			end
		endcase
	end

	// Link vector component, rounded half up from Q38 to Q16.
	always_comb begin
		rnd       = prod[49:0] + 50'd2097152;
		delta     = $signed(rnd[49:22]);
		pos_sum_x = 34'(end_x_q) + 34'(delta);
		pos_sum_y = 34'(end_y_q) + 34'(delta);
	end

	assign out_free = !out_valid_q || !out_stall;
	assign load_out = (state_q == T_OUT) && out_free;
	assign status_n = (jidx_q != link_count_q) || (int'(jidx_q) > MAX_LINKS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_count_q <= 7'd4;
			tol_q        <= 32'd66;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LINK_COUNT: link_count_q <= cfg_data[6:0];
				REG_TOLERANCE:  tol_q        <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			angle_q     <= '0;
			end_x_q     <= '0;
			end_y_q     <= '0;
			jidx_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				T_IDLE: begin
					if (in_valid)
						state_q <= T_ANG;
				end
				T_ANG: begin
					angle_q <= angle_n;
					state_q <= T_WAIT;
				end
				T_WAIT: begin
					if (sc_stat.done)
						state_q <= T_MX;
				end
				T_MX: state_q <= T_MY;
				T_MY: begin
					end_x_q <= sat_pos(pos_sum_x);
					state_q <= T_PY;
				end
				T_PY: begin
					end_y_q <= sat_pos(pos_sum_y);
					if (jidx_q != 7'd127)
						jidx_q <= jidx_q + 7'd1;
					state_q <= last_q ? T_SX : T_OUT;
				end
				T_SX: state_q <= T_SY;
				T_SY: state_q <= T_SR;
				T_SR: state_q <= T_ST;
				T_ST: state_q <= T_CMP;
				T_CMP: state_q <= T_OUT;
				T_OUT: begin
					if (out_free) begin
						state_q <= T_IDLE;
						if (last_q) begin
							angle_q <= '0;
							end_x_q <= '0;
							end_y_q <= '0;
							jidx_q  <= '0;
						end
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == T_IDLE) begin
			ang_in_q <= joint_angle;
			len_q    <= link_len;
			last_q   <= final_joint;
		end
		if (state_q == T_PY)
			res_q <= sat_ang(28'(angle_q) - TWO_PI_Q16);
		case (state_q)
			T_SY:  sum_q <= {1'b0, prod[63:0]};
			T_SR:  sum_q <= sum_q + {1'b0, prod[63:0]};
			T_ST:  sum_q <= sum_q + {1'b0, prod[63:0]};
			T_CMP: closes_q <= sum_q < {1'b0, prod[63:0]};
			default: ;
		endcase
		if (load_out) begin
			pos_x_q      <= end_x_q;
			pos_y_q      <= end_y_q;
			res_out_q    <= last_q ? res_q : '0;
			closes_out_q <= last_q & closes_q;
			status_out_q <= last_q & status_n;
			eoc_q        <= last_q;
		end
	end

	assign in_stall       = (state_q != T_IDLE);
	assign out_valid      = out_valid_q;
	assign pos_x          = pos_x_q;
	assign pos_y          = pos_y_q;
	assign angle_residual = res_out_q;
	assign closes         = closes_out_q;
	assign status         = status_out_q;
	assign end_of_chain   = eoc_q;

	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == T_OUT))
		else $error("result raised outside the output step");
	a_plain_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !eoc_q) |-> (res_out_q == '0 && !closes_out_q && !status_out_q))
		else $error("chain fields set on an intermediate result");
	a_chain_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && last_q) |=> (jidx_q == '0 && angle_q == '0 && end_x_q == '0))
		else $error("chain state not cleared after final joint");
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sc_stat.done |-> state_q == T_WAIT)
		else $error("sine unit finished outside wait step");

endmodule

`default_nettype wire
